>>> hdl/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg
// Shared constants, types and state codes of the count-min sketch.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam int unsigned MAX_COLUMNS = 1024;
  localparam int unsigned MAX_ROWS    = 8;
  localparam int unsigned KEY_BYTES   = 8;

  localparam int unsigned COL_W   = $clog2(MAX_COLUMNS);
  localparam int unsigned ROW_W   = $clog2(MAX_ROWS);
  localparam int unsigned ADDR_W  = ROW_W + COL_W;
  localparam int unsigned DEPTH   = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned CFGC_W  = 11;
  localparam int unsigned CFGR_W  = 4;
  localparam int unsigned IDX_W   = 4;

  localparam logic [31:0] ROW_SEED_BASE = 32'hc3157a5e;
  localparam logic [31:0] MM_MUL        = 32'h5bd1e995;
  localparam logic [31:0] CNT_MAX       = 32'hffffffff;

  localparam logic [IDX_W-1:0] REG_COLUMNS = 4'd0;
  localparam logic [IDX_W-1:0] REG_ROWS    = 4'd1;

  localparam logic OP_INCREMENT = 1'b0;
  localparam logic OP_QUERY     = 1'b1;

  typedef struct packed {
    logic              start;
    logic [63:0]       key;
    logic [31:0]       seed;
    logic [CFGC_W-1:0] cols;
  } hash_req_t;

  typedef struct packed {
    logic              done;
    logic [COL_W-1:0]  col;
  } hash_rsp_t;

  typedef enum logic [3:0] {
    H_IDLE, H_K0A, H_K0B, H_K1A, H_K1B, H_H0, H_H1, H_H2, H_MOD, H_DONE
  } hst_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_HSTART, ST_HWAIT, ST_CHECK, ST_UPDATE, ST_TOTAL, ST_OUT
  } st_t;

endpackage

>>> hdl/cms_ram.sv
// ----------------------------------------------------------------------------
// cms_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module cms_ram #(
  parameter int unsigned AW = 13,
  parameter int unsigned DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/cms_hash.sv
// ----------------------------------------------------------------------------
// cms_hash
// Column unit: MurmurHash2 of an 8-byte key on one shared multiplier,
// then a bit-serial remainder by the column count.
// ----------------------------------------------------------------------------
module cms_hash (
  input  logic                clk,
  input  logic                rst_n,
  input  cms_pkg::hash_req_t  req,
  output cms_pkg::hash_rsp_t  rsp
);

  cms_pkg::hst_t st_r, st_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] k0_r, k0_nxt;
  logic [31:0] k1_r, k1_nxt;
  logic [31:0] hi_r, hi_nxt;
  logic [31:0] seed_r, seed_nxt;
  logic [cms_pkg::CFGC_W-1:0] div_r, div_nxt;
  logic [cms_pkg::CFGC_W-1:0] rem_r, rem_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [31:0] prod;
  logic [31:0] t;
  logic [cms_pkg::CFGC_W:0] trial;

  assign prod = acc_r * cms_pkg::MM_MUL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= cms_pkg::H_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    acc_r  <= acc_nxt;
    k0_r   <= k0_nxt;
    k1_r   <= k1_nxt;
    hi_r   <= hi_nxt;
    seed_r <= seed_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
  end

  always_comb begin
    st_nxt   = st_r;
    acc_nxt  = acc_r;
    k0_nxt   = k0_r;
    k1_nxt   = k1_r;
    hi_nxt   = hi_r;
    seed_nxt = seed_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    t        = 32'd0;
    trial    = {rem_r, acc_r[31]};
    rsp.done = 1'b0;
    rsp.col  = rem_r[cms_pkg::COL_W-1:0];
    unique case (st_r)
      cms_pkg::H_IDLE: begin
        if (req.start) begin
          acc_nxt  = req.key[31:0];
          hi_nxt   = req.key[63:32];
          seed_nxt = req.seed;
          div_nxt  = req.cols;
          st_nxt   = cms_pkg::H_K0A;
        end
      end
      cms_pkg::H_K0A: begin
        acc_nxt = prod ^ (prod >> 24);
        st_nxt  = cms_pkg::H_K0B;
      end
      cms_pkg::H_K0B: begin
        k0_nxt  = prod;
        acc_nxt = hi_r;
        st_nxt  = cms_pkg::H_K1A;
      end
      cms_pkg::H_K1A: begin
        acc_nxt = prod ^ (prod >> 24);
        st_nxt  = cms_pkg::H_K1B;
      end
      cms_pkg::H_K1B: begin
        k1_nxt  = prod;
        acc_nxt = seed_r ^ 32'(cms_pkg::KEY_BYTES);
        st_nxt  = cms_pkg::H_H0;
      end
      cms_pkg::H_H0: begin
        acc_nxt = prod ^ k0_r;
        st_nxt  = cms_pkg::H_H1;
      end
      cms_pkg::H_H1: begin
        t       = prod ^ k1_r;
        acc_nxt = t ^ (t >> 13);
        st_nxt  = cms_pkg::H_H2;
      end
      cms_pkg::H_H2: begin
        acc_nxt = prod ^ (prod >> 15);
        rem_nxt = '0;
        cnt_nxt = 5'd31;
        st_nxt  = cms_pkg::H_MOD;
      end
      cms_pkg::H_MOD: begin
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = cms_pkg::CFGC_W'(trial - {1'b0, div_r});
        end else begin
          rem_nxt = trial[cms_pkg::CFGC_W-1:0];
        end
        acc_nxt = {acc_r[30:0], 1'b0};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          st_nxt = cms_pkg::H_DONE;
        end
      end
      cms_pkg::H_DONE: begin
        rsp.done = 1'b1;
        st_nxt   = cms_pkg::H_IDLE;
      end
      default: st_nxt = cms_pkg::H_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |=> !rsp.done) else $error("column done held");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> ({1'b0, rem_r} < {1'b0, div_r})) else $error("column beyond modulus");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == cms_pkg::H_MOD && cnt_r == 5'd0) |=> rsp.done) else $error("no done after remainder");
`endif

endmodule

>>> hdl/count_min_sketch_update_query.sv
// ----------------------------------------------------------------------------
// count_min_sketch_update_query
// Count-min sketch with 32-bit counters: increment with overflow and underflow check, query.
// ----------------------------------------------------------------------------
// After reset the block clears its 8192-entry counter memory, one entry a
// cycle, and takes no request until the clear is done. Requests are then
// handled one at a time. Each row in use runs the column unit (seven
// multiplier steps of the hash and a 32-step remainder), then one counter
// read; an increment that is not refused adds one write per row and one
// update of the total. A new request is taken while the last result waits.
module count_min_sketch_update_query (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [63:0]                       in_key,
  input  logic signed [32:0]                in_delta,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [31:0]                       out_estimate,
  output logic                              out_rejected,
  output logic [63:0]                       out_total_count,
  input  logic                              cfg_we,
  input  logic [cms_pkg::IDX_W-1:0]         cfg_index,
  input  logic [cms_pkg::CFGC_W-1:0]        cfg_wdata
);

  cms_pkg::st_t st_r, st_nxt;
  logic [cms_pkg::CFGC_W-1:0] cols_cfg_r;
  logic [cms_pkg::CFGR_W-1:0] rows_cfg_r;
  logic [cms_pkg::CFGC_W-1:0] cols_r, cols_nxt;
  logic [cms_pkg::ROW_W-1:0]  last_r, last_nxt;
  logic [cms_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic                       op_r, op_nxt;
  logic [63:0]                key_r, key_nxt;
  logic signed [32:0]         delta_r, delta_nxt;
  logic [31:0]                min_r, min_nxt;
  logic                       rej_r, rej_nxt;
  logic [63:0]                total_r, total_nxt;
  logic [cms_pkg::ADDR_W-1:0] clr_r, clr_nxt;
  logic [cms_pkg::COL_W-1:0]  col_r [cms_pkg::MAX_ROWS];
  logic [31:0]                val_r [cms_pkg::MAX_ROWS];
  logic                       out_valid_r, out_valid_nxt;
  logic [31:0]                out_est_r, out_est_nxt;
  logic                       out_rej_r, out_rej_nxt;
  logic [63:0]                out_tot_r, out_tot_nxt;

  cms_pkg::hash_req_t hreq;
  cms_pkg::hash_rsp_t hrsp;

  logic                       mem_we;
  logic [cms_pkg::ADDR_W-1:0] mem_waddr;
  logic [31:0]                mem_wdata;
  logic [cms_pkg::ADDR_W-1:0] mem_raddr;
  logic [31:0]                mem_rdata;

  logic signed [33:0] chk;
  logic [31:0]        newv;
  logic [64:0]        inc_sum;
  logic [32:0]        dec;
  logic [cms_pkg::CFGC_W-1:0] cols_eff;
  logic [cms_pkg::CFGR_W-1:0] rows_eff;
  logic               accept;

  cms_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .rsp   (hrsp)
  );

  cms_ram #(.AW(cms_pkg::ADDR_W), .DW(32)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    if (cols_cfg_r == '0) begin
      cols_eff = cms_pkg::CFGC_W'(1);
    end else if (cols_cfg_r > cms_pkg::CFGC_W'(cms_pkg::MAX_COLUMNS)) begin
      cols_eff = cms_pkg::CFGC_W'(cms_pkg::MAX_COLUMNS);
    end else begin
      cols_eff = cols_cfg_r;
    end
    if (rows_cfg_r == '0) begin
      rows_eff = cms_pkg::CFGR_W'(1);
    end else if (rows_cfg_r > cms_pkg::CFGR_W'(cms_pkg::MAX_ROWS)) begin
      rows_eff = cms_pkg::CFGR_W'(cms_pkg::MAX_ROWS);
    end else begin
      rows_eff = rows_cfg_r;
    end
  end

  assign in_stall = (st_r != cms_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= cms_pkg::ST_CLEAR;
      cols_cfg_r  <= cms_pkg::CFGC_W'(cms_pkg::MAX_COLUMNS);
      rows_cfg_r  <= cms_pkg::CFGR_W'(4);
      total_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      total_r     <= total_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == cms_pkg::REG_COLUMNS) begin
        cols_cfg_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == cms_pkg::REG_ROWS) begin
        rows_cfg_r <= cfg_wdata[cms_pkg::CFGR_W-1:0];
      end
    end
    cols_r    <= cols_nxt;
    last_r    <= last_nxt;
    row_r     <= row_nxt;
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    delta_r   <= delta_nxt;
    min_r     <= min_nxt;
    rej_r     <= rej_nxt;
    out_est_r <= out_est_nxt;
    out_rej_r <= out_rej_nxt;
    out_tot_r <= out_tot_nxt;
    if (st_r == cms_pkg::ST_HWAIT && hrsp.done) begin
      col_r[row_r] <= hrsp.col;
    end
    if (st_r == cms_pkg::ST_CHECK) begin
      val_r[row_r] <= mem_rdata;
    end
  end

  always_comb begin
    st_nxt        = st_r;
    cols_nxt      = cols_r;
    last_nxt      = last_r;
    row_nxt       = row_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    delta_nxt     = delta_r;
    min_nxt       = min_r;
    rej_nxt       = rej_r;
    total_nxt     = total_r;
    clr_nxt       = clr_r;
    out_est_nxt   = out_est_r;
    out_rej_nxt   = out_rej_r;
    out_tot_nxt   = out_tot_r;
    out_valid_nxt = out_valid_r && out_stall;
    hreq.start    = 1'b0;
    hreq.key      = key_r;
    hreq.seed     = cms_pkg::ROW_SEED_BASE + {{(32-cms_pkg::ROW_W){1'b0}}, row_r};
    hreq.cols     = cols_r;
    mem_we        = 1'b0;
    mem_waddr     = {row_r, col_r[row_r]};
    mem_wdata     = '0;
    mem_raddr     = {row_r, hrsp.col};
    chk           = $signed({2'b00, mem_rdata}) + $signed({delta_r[32], delta_r});
    newv          = val_r[row_r] + delta_r[31:0];
    inc_sum       = {1'b0, total_r} + {32'd0, delta_r[31:0]};
    dec           = 33'(-delta_r);
    unique case (st_r)
      cms_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + cms_pkg::ADDR_W'(1);
        if (clr_r == '1) begin
          st_nxt = cms_pkg::ST_IDLE;
        end
      end
      cms_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_operation;
          key_nxt   = in_key;
          delta_nxt = in_delta;
          cols_nxt  = cols_eff;
          last_nxt  = cms_pkg::ROW_W'(rows_eff - cms_pkg::CFGR_W'(1));
          row_nxt   = '0;
          min_nxt   = cms_pkg::CNT_MAX;
          rej_nxt   = 1'b0;
          st_nxt    = cms_pkg::ST_HSTART;
        end
      end
      cms_pkg::ST_HSTART: begin
        hreq.start = 1'b1;
        st_nxt     = cms_pkg::ST_HWAIT;
      end
      cms_pkg::ST_HWAIT: begin
        if (hrsp.done) begin
          st_nxt = cms_pkg::ST_CHECK;
        end
      end
      cms_pkg::ST_CHECK: begin
        if (mem_rdata < min_r) begin
          min_nxt = mem_rdata;
        end
        if (op_r == cms_pkg::OP_INCREMENT && (chk[33] || chk[32])) begin
          rej_nxt = 1'b1;
        end
        if (row_r == last_r) begin
          row_nxt = '0;
          if (op_r == cms_pkg::OP_QUERY || rej_nxt) begin
            st_nxt = cms_pkg::ST_OUT;
          end else begin
            min_nxt = cms_pkg::CNT_MAX;
            st_nxt  = cms_pkg::ST_UPDATE;
          end
        end else begin
          row_nxt = row_r + cms_pkg::ROW_W'(1);
          st_nxt  = cms_pkg::ST_HSTART;
        end
      end
      cms_pkg::ST_UPDATE: begin
        mem_we    = 1'b1;
        mem_wdata = newv;
        if (newv < min_r) begin
          min_nxt = newv;
        end
        if (row_r == last_r) begin
          st_nxt = cms_pkg::ST_TOTAL;
        end else begin
          row_nxt = row_r + cms_pkg::ROW_W'(1);
        end
      end
      cms_pkg::ST_TOTAL: begin
        if (delta_r[32]) begin
          if ({31'd0, dec} > total_r) begin
            total_nxt = '0;
          end else begin
            total_nxt = total_r - {31'd0, dec};
          end
        end else if (inc_sum[64]) begin
          total_nxt = '1;
        end else begin
          total_nxt = inc_sum[63:0];
        end
        st_nxt = cms_pkg::ST_OUT;
      end
      cms_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_est_nxt   = rej_r ? 32'd0 : min_r;
          out_rej_nxt   = rej_r;
          out_tot_nxt   = total_r;
          st_nxt        = cms_pkg::ST_IDLE;
        end
      end
      default: st_nxt = cms_pkg::ST_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_estimate    = out_est_r;
  assign out_rejected    = out_rej_r;
  assign out_total_count = out_tot_r;

`ifndef SYNTHESIS
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == cms_pkg::ST_CLEAR && mem_we) |-> (mem_wdata == 32'd0))
    else $error("clear pass writes nonzero");
  a_rej_est: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rejected) |-> (out_estimate == 32'd0))
    else $error("rejected request with estimate");
  a_rej_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && st_r != cms_pkg::ST_CLEAR) |-> (!rej_r && op_r == cms_pkg::OP_INCREMENT))
    else $error("counter written for rejected request or query");
  a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != cms_pkg::ST_TOTAL) |=> $stable(total_r))
    else $error("total moved outside update");
`endif

endmodule

>>> tb/sv/tb_count_min_sketch_update_query.sv
// ----------------------------------------------------------------------------
// tb_count_min_sketch_update_query
// Self-checking bench for the count-min sketch: increments, queries and the
// overflow/underflow refusal are driven through the request channel, with
// the column and row registers swept between phases. A local sketch model
// predicts every result, and results are compared in order.
// ----------------------------------------------------------------------------
module tb_count_min_sketch_update_query;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned PER_PHASE   = 185;

  typedef struct {
    logic [31:0] estimate;
    logic        rejected;
    logic [63:0] total_count;
  } sketch_rsp_t;

  typedef struct {
    logic               operation;
    logic [63:0]        key;
    logic signed [32:0] delta;
    bit                 typed;
    logic [31:0]        estimate;
    logic               rejected;
  } stim_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_operation;
  logic [63:0]                in_key;
  logic signed [32:0]         in_delta;
  logic                       out_valid;
  logic                       out_stall;
  logic [31:0]                out_estimate;
  logic                       out_rejected;
  logic [63:0]                out_total_count;
  logic                       cfg_we;
  logic [cms_pkg::IDX_W-1:0]  cfg_index;
  logic [cms_pkg::CFGC_W-1:0] cfg_wdata;

  logic [31:0]   counters [cms_pkg::DEPTH];
  logic [63:0]   sketch_total;
  logic [10:0]   cols_reg;
  logic [3:0]    rows_reg;
  sketch_rsp_t   pending_rsp [$];
  int unsigned   errors;
  int unsigned   cycles;
  int unsigned   n_requests;
  int unsigned   n_refused;
  int unsigned   n_queries;
  bit            quiet;
  logic [63:0]   key_pool [16];

  count_min_sketch_update_query dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("count_min_sketch_update_query: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] murmur2(logic [63:0] k, logic [31:0] seed);
    logic [31:0] h;
    logic [31:0] w;
    h = seed ^ 32'd8;
    for (int i = 0; i < 2; i++) begin
      w = k[32*i +: 32];
      w = w * cms_pkg::MM_MUL;
      w = w ^ (w >> 24);
      w = w * cms_pkg::MM_MUL;
      h = h * cms_pkg::MM_MUL;
      h = h ^ w;
    end
    h = h ^ (h >> 13);
    h = h * cms_pkg::MM_MUL;
    h = h ^ (h >> 15);
    return h;
  endfunction

  function automatic sketch_rsp_t apply_request(logic op, logic [63:0] k,
                                                logic signed [32:0] d);
    sketch_rsp_t rsp;
    int unsigned ncols;
    int unsigned nrows;
    int unsigned slot [cms_pkg::MAX_ROWS];
    longint      sum;
    longint      dl;
    logic [63:0] mag;
    logic [31:0] lowest;
    ncols  = (cols_reg == 0) ? 1 :
             (cols_reg > cms_pkg::MAX_COLUMNS) ? cms_pkg::MAX_COLUMNS : cols_reg;
    nrows  = (rows_reg == 0) ? 1 :
             (rows_reg > cms_pkg::MAX_ROWS) ? cms_pkg::MAX_ROWS : rows_reg;
    dl     = longint'(d);
    lowest = cms_pkg::CNT_MAX;
    for (int r = 0; r < nrows; r++)
      slot[r] = r * cms_pkg::MAX_COLUMNS
              + (murmur2(k, cms_pkg::ROW_SEED_BASE + r) % ncols);
    rsp.rejected = 1'b0;
    if (op == cms_pkg::OP_INCREMENT) begin
      for (int r = 0; r < nrows; r++) begin
        sum = longint'({32'd0, counters[slot[r]]}) + dl;
        if (sum < 0 || sum > longint'({32'd0, cms_pkg::CNT_MAX})) rsp.rejected = 1'b1;
      end
      if (!rsp.rejected) begin
        for (int r = 0; r < nrows; r++)
          counters[slot[r]] = counters[slot[r]] + dl[31:0];
        if (dl > 0) begin
          mag = dl;
          sketch_total = (sketch_total > ~mag) ? '1 : sketch_total + mag;
        end else if (dl < 0) begin
          mag = -dl;
          sketch_total = (mag > sketch_total) ? 64'd0 : sketch_total - mag;
        end
      end
    end
    for (int r = 0; r < nrows; r++)
      if (counters[slot[r]] < lowest) lowest = counters[slot[r]];
    rsp.estimate    = rsp.rejected ? 32'd0 : lowest;
    rsp.total_count = sketch_total;
    return rsp;
  endfunction

  // drive one request; hold payload until taken
  task automatic send_request(logic op, logic [63:0] k, logic signed [32:0] d,
                              bit typed, logic [31:0] t_est, logic t_rej);
    sketch_rsp_t rsp;
    int unsigned gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_key       = k;
    in_delta     = d;
    do @(posedge clk); while (in_stall);
    rsp = apply_request(op, k, d);
    if (typed) begin
      rsp.estimate = t_est;
      rsp.rejected = t_rej;
    end
    pending_rsp.push_back(rsp);
    n_requests++;
    if (op == cms_pkg::OP_QUERY) n_queries++;
    if (rsp.rejected) n_refused++;
  endtask

  task automatic drain_and_write(logic [10:0] cols, logic [3:0] rows);
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (400) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = cms_pkg::REG_COLUMNS;
    cfg_wdata = cols;
    @(negedge clk);
    cfg_index = cms_pkg::REG_ROWS;
    cfg_wdata = {7'd0, rows};
    @(negedge clk);
    cfg_index = 4'd9;
    cfg_wdata = '1;
    @(negedge clk);
    cfg_we    = 1'b0;
    cols_reg  = cols;
    rows_reg  = rows;
  endtask

  always @(negedge clk) begin : receiver_stall
    int unsigned hold;
    if (hold > 0) begin
      hold--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      hold = $urandom_range(0, 3);
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    sketch_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected result est=%h rej=%b tot=%h", $time,
                 out_estimate, out_rejected, out_total_count);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (out_estimate !== want.estimate) begin
          $display("%0t estimate exp %h got %h", $time, want.estimate, out_estimate);
          errors++;
        end
        if (out_rejected !== want.rejected) begin
          $display("%0t rejected exp %b got %b", $time, want.rejected, out_rejected);
          errors++;
        end
        if (out_total_count !== want.total_count) begin
          $display("%0t total_count exp %h got %h", $time, want.total_count,
                   out_total_count);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [32:0] pick_delta();
    unique case ($urandom_range(0, 7))
      0, 1, 2: return 33'(longint'($urandom_range(0, 200)) - 60);
      3:       return {1'b0, $urandom()};
      4:       return {1'b1, $urandom()};
      5:       return 33'sh0_ffff_ffff;
      6:       return -33'(longint'($urandom_range(1, 1000)));
      default: return 33'(longint'($urandom_range(1, 5000)));
    endcase
  endfunction

  stim_row_t directed [16];
  logic [10:0] ph_cols [N_PHASES];
  logic [3:0]  ph_rows [N_PHASES];

  initial begin
    logic [63:0] k;
    logic        op;
    errors = 0; cycles = 0; n_requests = 0; n_refused = 0; n_queries = 0;
    quiet = 1'b0;
    rst_n = 1'b0; in_valid = 1'b0; in_operation = 1'b0; in_key = '0; in_delta = '0;
    out_stall = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    for (int i = 0; i < cms_pkg::DEPTH; i++) counters[i] = 32'd0;
    sketch_total = 64'd0;
    cols_reg = 11'd1024;
    rows_reg = 4'd4;

    directed = '{
      '{cms_pkg::OP_QUERY,     64'd0,  33'sd0,           1, 32'd0,        1'b0},
      '{cms_pkg::OP_INCREMENT, 64'd0,  -33'sd1,          1, 32'd0,        1'b1},
      '{cms_pkg::OP_INCREMENT, 64'd0,  33'sh0_ffff_ffff, 1, 32'hffffffff, 1'b0},
      '{cms_pkg::OP_INCREMENT, 64'd0,  33'sd1,           1, 32'd0,        1'b1},
      '{cms_pkg::OP_QUERY,     64'd0,  -33'sd1,          1, 32'hffffffff, 1'b0},
      '{cms_pkg::OP_INCREMENT, '1,     33'sh1_0000_0000, 1, 32'd0,        1'b1},
      '{cms_pkg::OP_INCREMENT, '1,     33'sd5,           0, 32'd0,        1'b0},
      '{cms_pkg::OP_QUERY,     '1,     33'sd0,           0, 32'd0,        1'b0},
      '{cms_pkg::OP_INCREMENT, 64'd0,  -33'sd4294967295, 0, 32'd0,        1'b0},
      '{cms_pkg::OP_INCREMENT, 64'h8000_0000_0000_0001, 33'sd0, 0, 32'd0, 1'b0},
      '{cms_pkg::OP_INCREMENT, 64'h0123_4567_89ab_cdef, 33'sd7, 0, 32'd0, 1'b0},
      '{cms_pkg::OP_INCREMENT, 64'h0123_4567_89ab_cdef, -33'sd10, 0, 32'd0, 1'b0},
      '{cms_pkg::OP_INCREMENT, 64'h0123_4567_89ab_cdef, -33'sd7, 0, 32'd0, 1'b0},
      '{cms_pkg::OP_QUERY,     64'h0123_4567_89ab_cdef, 33'sh1_ffff_ffff, 0, 32'd0,
        1'b0},
      '{cms_pkg::OP_INCREMENT, 64'h5555_aaaa_5555_aaaa, 33'sd1000, 0, 32'd0, 1'b0},
      '{cms_pkg::OP_INCREMENT, 64'h5555_aaaa_5555_aaaa, -33'sd2000, 0, 32'd0, 1'b0}
    };
    ph_cols = '{11'd1,  11'd0,  11'd2047, 11'd1024, 11'd3, 11'd17, 11'd1000, 11'd5};
    ph_rows = '{4'd1,   4'd0,   4'd15,    4'd8,     4'd2,  4'd3,  4'd5,      4'd4};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i])
      send_request(directed[i].operation, directed[i].key, directed[i].delta,
                   directed[i].typed, directed[i].estimate, directed[i].rejected);

    for (int p = 0; p < N_PHASES; p++) begin
      drain_and_write(ph_cols[p], ph_rows[p]);
      foreach (key_pool[j]) key_pool[j] = {$urandom(), $urandom()};
      if (p == N_PHASES - 1) quiet = 1'b1;
      for (int n = 0; n < PER_PHASE; n++) begin
        k  = ($urandom_range(0, 4) == 0) ? {$urandom(), $urandom()}
                                         : key_pool[$urandom_range(0, 15)];
        op = ($urandom_range(0, 9) < 3) ? cms_pkg::OP_QUERY : cms_pkg::OP_INCREMENT;
        send_request(op, k, pick_delta(), 0, 32'd0, 1'b0);
      end
    end

    @(negedge clk);
    in_valid  = 1'b0;
    out_stall = 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (400) @(posedge clk);
    $display("covered %0d requests (%0d queries, %0d refused) over %0d register settings",
             n_requests, n_queries, n_refused, N_PHASES + 1);
    if (errors == 0 && pending_rsp.size() == 0)
      $display("count_min_sketch_update_query: match");
    else
      $display("count_min_sketch_update_query: mismatch");
    $finish;
  end

endmodule
